[rtl/core/block_pool_allocator_defines.svh]
// Assertion macros shared by the pool allocator modules.
// Each macro expects clk and rst in the scope where it is used.
`ifndef BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int POOL_BLOCKS = 4096;
  localparam int BLOCK_BYTES = 32;

  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 12;
  localparam int IDX_W    = $clog2(POOL_BLOCKS);

  // Bitmap word organization: words of lanes, lanes of bits.
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LANE_BITS = 8;
  localparam int LANES     = WORD_BITS / LANE_BITS;
  localparam int LSEL_W    = $clog2(LANES);
  localparam int WORDS     = (POOL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Summary bits (one per word) are searched group first, then word.
  localparam int GRP_WORDS = 8;
  localparam int GSUB_W    = $clog2(GRP_WORDS);
  localparam int GROUPS    = (WORDS + GRP_WORDS - 1) / GRP_WORDS;
  localparam int GSEL_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SUM_BITS  = GROUPS * GRP_WORDS;

  // Offset-to-index division by reciprocal multiply with one correction step.
  localparam longint SPAN    = longint'(POOL_BLOCKS) * longint'(BLOCK_BYTES);
  localparam int     OFF_W   = $clog2(SPAN);
  localparam int     RECIP_W = OFF_W + 1;
  localparam longint RECIP   = (longint'(1) << OFF_W) / longint'(BLOCK_BYTES);
  localparam int     PROD_W  = OFF_W + RECIP_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic req_load;
    logic grp_find;
    logic word_find;
    logic byte_find;
    logic alloc_wr;
    logic addr_load;
    logic full_load;
    logic off_load;
    logic mul_load;
    logic qb_load;
    logic corr_load;
    logic free_set;
    logic outside_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic any_free;
    logic in_range;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

[rtl/core/bpa_req_if.sv]
`timescale 1ns / 1ps
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, cmd, release_address, input ready);
  modport sink   (input valid, cmd, release_address, output ready);
endinterface

[rtl/core/bpa_rsp_if.sv]
`timescale 1ns / 1ps
interface bpa_rsp_if import bpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  block_index;
  logic [ADDR_W-1:0]   block_address;

  modport source (output valid, status, block_index, block_address, input ready);
  modport sink   (input valid, status, block_index, block_address, output ready);
endinterface

[rtl/core/block_pool_allocator.sv]
`timescale 1ns / 1ps
// Request to result: allocate steps through group, word and byte search, bitmap write
// and address load; free through offset, multiply, quotient, correction, RAM read and set;
// pool full and an outside address end early. Results wait while one is still pending.
// One request at a time; the next is taken the cycle after the result is registered.
// The bitmap word RAM has one read and one write port; both paths read-modify-write it.
// Synchronous reset: pool_base clears to 0 and every block reads free at once (per-word
// valid flags, no clearing pass).
module block_pool_allocator import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  bpa_req_if.sink           req,
  bpa_rsp_if.source         rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (op_t'(req.cmd)),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_addr     (req.release_address),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_index   (rsp.block_index),
    .rsp_address (rsp.block_address)
  );

endmodule

[rtl/core/bpa_ram.sv]
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bpa_ctrl.sv]
`timescale 1ns / 1ps
`include "block_pool_allocator_defines.svh"
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  op_t      in_op,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_GRP   = 12'b0000_0000_0010,
    S_WORD  = 12'b0000_0000_0100,
    S_BYTE  = 12'b0000_0000_1000,
    S_AWR   = 12'b0000_0001_0000,
    S_ADDR  = 12'b0000_0010_0000,
    S_FOFF  = 12'b0000_0100_0000,
    S_FMUL  = 12'b0000_1000_0000,
    S_FQB   = 12'b0001_0000_0000,
    S_FCORR = 12'b0010_0000_0000,
    S_FRD   = 12'b0100_0000_0000,
    S_FSET  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   slot_ok;

  assign slot_ok = !stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = (in_op == CMD_ALLOC) ? S_GRP : S_FOFF;
        end
      end
      S_GRP: begin
        if (!stat.any_free) begin
          // hold until the result register can take the full status
          if (slot_ok) begin
            cmd.full_load = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.grp_find = 1'b1;
          state_next   = S_WORD;
        end
      end
      S_WORD: begin
        cmd.word_find = 1'b1;
        state_next    = S_BYTE;
      end
      S_BYTE: begin
        cmd.byte_find = 1'b1;
        state_next    = S_AWR;
      end
      S_AWR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_ADDR;
      end
      S_ADDR: begin
        if (slot_ok) begin
          cmd.addr_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FOFF: begin
        cmd.off_load = 1'b1;
        state_next   = S_FMUL;
      end
      S_FMUL: begin
        if (!stat.in_range) begin
          if (slot_ok) begin
            cmd.outside_load = 1'b1;
            state_next       = S_IDLE;
          end
        end else begin
          cmd.mul_load = 1'b1;
          state_next   = S_FQB;
        end
      end
      S_FQB: begin
        cmd.qb_load = 1'b1;
        state_next  = S_FCORR;
      end
      S_FCORR: begin
        cmd.corr_load = 1'b1;
        state_next    = S_FRD;
      end
      S_FRD: begin
        state_next = S_FSET;
      end
      S_FSET: begin
        // the bitmap write and the result load go together, exactly once
        if (slot_ok) begin
          cmd.free_set = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BPA_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE,
                  "request transfer did not start work")
  `BPA_ASSERT_IMP(a_no_result_overwrite,
                  cmd.full_load || cmd.outside_load || cmd.addr_load || cmd.free_set,
                  !stat.out_busy, "result loaded while previous result still pending")

endmodule

[rtl/core/bpa_dp.sv]
`timescale 1ns / 1ps
`include "block_pool_allocator_defines.svh"
module bpa_dp import bpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [ADDR_W-1:0]   in_addr,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] rsp_status,
  output logic [INDEX_W-1:0]  rsp_index,
  output logic [ADDR_W-1:0]   rsp_address
);

  logic [ADDR_W-1:0]    pool_base;
  logic [ADDR_W-1:0]    req_addr;
  logic [WORDS-1:0]     summary;
  logic [WORDS-1:0]     word_valid;
  logic [GSEL_W-1:0]    grp;
  logic [WADDR_W-1:0]   word_sel;
  logic [LSEL_W-1:0]    lane_sel;
  logic [WORD_BITS-1:0] eff_word;
  logic [IDX_W-1:0]     idx;
  logic [OFF_W-1:0]     off;
  logic                 in_range;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     q;
  logic [OFF_W-1:0]     qb;

  logic [SUM_BITS-1:0]  sum_pad;
  logic [GROUPS-1:0]    group_any;
  logic [GSEL_W-1:0]    grp_found;
  logic [GSUB_W-1:0]    sub_found;
  logic [WADDR_W-1:0]   word_found;
  logic [WADDR_W-1:0]   widx;
  logic [WADDR_W-1:0]   word_src;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] eff_now;
  logic [LANES-1:0]     lane_any;
  logic [LSEL_W-1:0]    lane_found;
  logic [2:0]           bit_found;
  logic [BIT_W-1:0]     abit;
  logic [BIT_W-1:0]     fbit;
  logic [31:0]          alloc_idx32;
  logic [WORD_BITS-1:0] new_alloc;
  logic [WORD_BITS-1:0] new_free;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    off32;
  logic [IDX_W-1:0]     q_next;
  logic [OFF_W:0]       rem;

  // Blocks past the end of the pool never read as free.
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WADDR_W-1:0] w);
    logic [WORD_BITS-1:0] m;
    for (int j = 0; j < WORD_BITS; j++) begin
      m[j] = ((32'(w) * WORD_BITS + 32'(j)) < 32'(POOL_BLOCKS));
    end
    return m;
  endfunction

  function automatic logic [GSEL_W-1:0] first_grp(input logic [GROUPS-1:0] v);
    logic [GSEL_W-1:0] r;
    r = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (v[i]) r = GSEL_W'(i);
    end
    return r;
  endfunction

  // Two-level search over the summary bits.
  assign sum_pad = SUM_BITS'(summary);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_any[g] = |sum_pad[g*GRP_WORDS +: GRP_WORDS];
    end
  end

  assign grp_found  = first_grp(group_any);
  assign sub_found  = GSUB_W'(first_set8(8'(sum_pad[grp*GRP_WORDS +: GRP_WORDS])));
  assign word_found = WADDR_W'(32'(grp) * GRP_WORDS + 32'(sub_found));

  assign widx     = WADDR_W'(32'(idx) >> BIT_W);
  assign word_src = cmd.byte_find ? word_sel : widx;
  assign eff_now  = word_valid[word_src] ? rdata : reset_word(word_src);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_any[l] = |eff_now[l*LANE_BITS +: LANE_BITS];
    end
  end

  assign lane_found  = LSEL_W'(first_set8(8'(lane_any)));
  assign bit_found   = first_set8(8'(eff_word[lane_sel*LANE_BITS +: LANE_BITS]));
  assign abit        = BIT_W'(32'(lane_sel) * LANE_BITS + 32'(bit_found));
  assign alloc_idx32 = 32'(word_sel) * WORD_BITS + 32'(abit);
  assign new_alloc   = eff_word & ~(WORD_BITS'(1) << abit);
  assign fbit        = BIT_W'(idx);
  assign new_free    = eff_now | (WORD_BITS'(1) << fbit);

  assign ram_we    = cmd.alloc_wr || cmd.free_set;
  assign ram_waddr = cmd.alloc_wr ? word_sel : widx;
  assign ram_wdata = cmd.alloc_wr ? new_alloc : new_free;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cmd.word_find ? word_found : widx),
    .rdata (rdata)
  );

  assign off32  = req_addr - pool_base;
  assign q_next = IDX_W'(prod >> OFF_W);
  assign rem    = (OFF_W + 1)'(off) - (OFF_W + 1)'(qb);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      summary    <= '1;
      word_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) pool_base <= cfg_data;
      if (ram_we) begin
        word_valid[ram_waddr] <= 1'b1;
        summary[ram_waddr]    <= cmd.alloc_wr ? (|new_alloc) : 1'b1;
      end
      if (cmd.full_load || cmd.outside_load || cmd.addr_load || cmd.free_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load)  req_addr <= in_addr;
    if (cmd.grp_find)  grp <= grp_found;
    if (cmd.word_find) word_sel <= word_found;
    if (cmd.byte_find) begin
      eff_word <= eff_now;
      lane_sel <= lane_found;
    end
    if (cmd.alloc_wr) idx <= IDX_W'(alloc_idx32);
    if (cmd.off_load) begin
      off      <= OFF_W'(off32);
      in_range <= (off32 < ADDR_W'(SPAN));
    end
    if (cmd.mul_load) prod <= PROD_W'(off) * PROD_W'(RECIP);
    if (cmd.qb_load) begin
      q  <= q_next;
      qb <= OFF_W'(32'(q_next) * 32'(BLOCK_BYTES));
    end
    // estimate is low by at most one
    if (cmd.corr_load) idx <= (rem >= (OFF_W + 1)'(BLOCK_BYTES)) ? q + IDX_W'(1) : q;

    if (cmd.full_load) begin
      rsp_status  <= ST_FULL;
      rsp_index   <= '0;
      rsp_address <= '0;
    end
    if (cmd.outside_load) begin
      rsp_status  <= ST_OUTSIDE;
      rsp_index   <= '0;
      rsp_address <= '0;
    end
    if (cmd.addr_load) begin
      rsp_status  <= ST_DONE;
      rsp_index   <= INDEX_W'(idx);
      rsp_address <= pool_base + 32'(idx) * 32'(BLOCK_BYTES);
    end
    if (cmd.free_set) begin
      rsp_status  <= ST_DONE;
      rsp_index   <= INDEX_W'(idx);
      rsp_address <= '0;
    end
  end

  assign stat.any_free = |summary;
  assign stat.in_range = in_range;
  assign stat.out_busy = rsp_valid && !rsp_ready;

  `BPA_ASSERT_IMP(a_alloc_bit_free, cmd.alloc_wr, eff_word[abit],
                  "allocated block was not free")
  `BPA_ASSERT_IMP(a_alloc_in_pool, cmd.alloc_wr, alloc_idx32 < 32'(POOL_BLOCKS),
                  "allocated index beyond pool")
  `BPA_ASSERT_IMP(a_free_in_range, cmd.free_set, in_range,
                  "free written for an address outside the pool")

endmodule
